### rtl/lzpp_pkg.sv
// Shared types and constants for the LZ76 phrase profile block.
// Used by the channel interfaces, the cell, the tree and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lzpp_pkg;

   localparam int NUMBER_BITS = 11;
   localparam int GROUP_SIZE  = 32;

   typedef struct packed {
      logic update;
      logic starting;
      logic store;
   } lzpp_cell_ctrl_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MATCH = 5'b00010,
      ST_RED1  = 5'b00100,
      ST_RED2  = 5'b01000,
      ST_FINAL = 5'b10000
   } lzpp_state_type;

endpackage

`default_nettype wire

### rtl/lzpp_channels.sv
// Valid/ready channel interfaces for symbol requests and phrase responses.
// Depends on lzpp_pkg for the phrase number width.
`timescale 1ns / 1ps
`default_nettype none

interface lzpp_req_if #(
   parameter int SYMBOL_BITS = 8
);
   logic                   valid;
   logic                   ready;
   logic [SYMBOL_BITS-1:0] symbol;
   logic                   first;

   modport source (output valid, output symbol, output first, input ready);
   modport sink   (input valid, input symbol, input first, output ready);
endinterface

interface lzpp_rsp_if;
   import lzpp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] phrase_number;
   logic                   phrase_closed;
   logic                   overflow;

   modport source (output valid, output phrase_number, output phrase_closed,
                   output overflow, input ready);
   modport sink   (input valid, input phrase_number, input phrase_closed,
                   input overflow, output ready);
endinterface

`default_nettype wire

### rtl/lzpp_cell.sv
// One history position: stored symbol and the match-end flag of the phrase.
// The match flag is handed to the next cell. Depends on lzpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzpp_cell #(
   parameter int SYMBOL_BITS = 8,
   parameter int POS_BITS    = 11,
   parameter int INDEX       = 0
) (
   input  wire                           clock,
   input  lzpp_pkg::lzpp_cell_ctrl_type  ctrl,
   input  wire  [POS_BITS-1:0]           pos,
   input  wire  [SYMBOL_BITS-1:0]        symbol,
   input  wire                           match_prev,
   output logic                          match_out
);
   import lzpp_pkg::*;

   logic [SYMBOL_BITS-1:0] hist_ff;
   logic                   match_ff;
   logic                   match_in;
   logic                   live;

   assign live     = POS_BITS'(INDEX) < pos;
   assign match_in = live && (hist_ff == symbol) && (ctrl.starting || match_prev);
   assign match_out = match_ff;

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         match_ff <= match_in;
         if (ctrl.store && (pos == POS_BITS'(INDEX))) begin
            hist_ff <= symbol;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/lzpp_any_tree.sv
// Two-level registered OR tree that tells whether any cell holds a match.
// Depends on lzpp_pkg for the group size.
`timescale 1ns / 1ps
`default_nettype none

module lzpp_any_tree #(
   parameter int WIDTH = 1024
) (
   input  wire              clock,
   input  wire  [WIDTH-1:0] bits,
   output logic             any
);
   import lzpp_pkg::*;

   localparam int NG1 = (WIDTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NG2 = (NG1 + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [NG1*GROUP_SIZE-1:0] pad1;
   logic [NG1-1:0]            lvl1_ff;
   logic [NG2*GROUP_SIZE-1:0] pad2;
   logic [NG2-1:0]            lvl2_ff;

   assign pad1 = (NG1*GROUP_SIZE)'(bits);
   assign pad2 = (NG2*GROUP_SIZE)'(lvl1_ff);

   always_ff @(posedge clock) begin
      for (int g = 0; g < NG1; g++) begin
         lvl1_ff[g] <= |pad1[g*GROUP_SIZE +: GROUP_SIZE];
      end
      for (int g = 0; g < NG2; g++) begin
         lvl2_ff[g] <= |pad2[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   assign any = |lvl2_ff;

endmodule

`default_nettype wire

### rtl/lz76_phrase_profile.sv
// LZ76 phrase profile: one result per symbol, with phrase number and close flag.
// A symbol is taken in the idle state, then passes the match state of the cell row,
// the two registered OR tree levels and the result state, which sets response valid.
// One symbol is in flight, so no new symbol is taken until the last has left the result state.
// A stalled response holds the next symbol in its result cycle.
// Reset (synchronous, active high) empties the string; history needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module lz76_phrase_profile #(
   parameter int MAX_LEN     = 1024,
   parameter int SYMBOL_BITS = 8
) (
   input  wire          clock,
   input  wire          reset,
   lzpp_req_if.sink     req_chan,
   lzpp_rsp_if.source   rsp_chan
);
   import lzpp_pkg::*;

   localparam int PW = $clog2(MAX_LEN + 1);
   localparam int NW = (PW > NUMBER_BITS) ? PW : NUMBER_BITS;

   lzpp_state_type         state_ff, state_in;
   logic [SYMBOL_BITS-1:0] sym_ff;
   logic                   first_ff;
   logic                   ovf_ff;
   logic [PW-1:0]          position_ff;
   logic [PW-1:0]          done_ff;
   logic                   starting_ff;
   logic                   rsp_valid_ff;
   logic [NUMBER_BITS-1:0] number_ff;
   logic                   closed_ff;
   logic                   overflow_ff;

   logic [PW-1:0]          eff_pos;
   logic [PW-1:0]          eff_done;
   logic                   eff_starting;
   logic                   eff_ovf;
   logic                   any;
   logic                   finish;
   logic [NW-1:0]          number_wide;
   lzpp_cell_ctrl_type     ctrl;
   logic [MAX_LEN:0]       chain;

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign eff_pos      = first_ff ? '0 : position_ff;
   assign eff_done     = first_ff ? '0 : done_ff;
   assign eff_starting = first_ff | starting_ff;
   assign eff_ovf      = eff_pos >= PW'(MAX_LEN);

   assign ctrl.update   = (state_ff == ST_MATCH);
   assign ctrl.starting = eff_starting;
   assign ctrl.store    = !eff_ovf;

   assign chain[0] = 1'b0;

   for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
      lzpp_cell #(
         .SYMBOL_BITS (SYMBOL_BITS),
         .POS_BITS    (PW),
         .INDEX       (j)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (eff_pos),
         .symbol     (sym_ff),
         .match_prev (chain[j]),
         .match_out  (chain[j+1])
      );
   end

   lzpp_any_tree #(
      .WIDTH (MAX_LEN)
   ) u_tree (
      .clock (clock),
      .bits  (chain[MAX_LEN:1]),
      .any   (any)
   );

   assign finish = (state_ff == ST_FINAL) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (ovf_ff && starting_ff) begin
         number_wide = NW'(done_ff);
      end else begin
         number_wide = NW'(done_ff) + NW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: state_in = ST_RED1;
         ST_RED1:  state_in = ST_RED2;
         ST_RED2:  state_in = ST_FINAL;
         ST_FINAL: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= '0;
         done_ff      <= '0;
         starting_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_chan.valid && req_chan.ready) begin
            sym_ff   <= req_chan.symbol;
            first_ff <= req_chan.first;
         end
         if (state_ff == ST_MATCH) begin
            ovf_ff      <= eff_ovf;
            done_ff     <= eff_done;
            starting_ff <= eff_starting;
            if (!eff_ovf) begin
               position_ff <= eff_pos + PW'(1);
            end else begin
               position_ff <= eff_pos;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            number_ff    <= number_wide[NUMBER_BITS-1:0];
            overflow_ff  <= ovf_ff;
            closed_ff    <= !ovf_ff && !any;
            if (!ovf_ff) begin
               starting_ff <= !any;
               if (!any) begin
                  done_ff <= done_ff + PW'(1);
               end
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.phrase_number = number_ff;
   assign rsp_chan.phrase_closed = closed_ff;
   assign rsp_chan.overflow      = overflow_ff;

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINAL))
      else $error("Response appeared without a finished symbol.");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      position_ff <= PW'(MAX_LEN))
      else $error("String position ran past its capacity.");

   a_overflow_not_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(overflow_ff && closed_ff))
      else $error("Overflowed symbol reported as closing a phrase.");

endmodule

`default_nettype wire

### bench/tb_lz76_phrase_profile.sv
`timescale 1ns / 1ps
// Testbench for lz76_phrase_profile: streams strings of symbols, predicts the
// phrase number, close and overflow flags of each one and checks every response.
// Depends on lzpp_pkg, the channel interfaces and the lz76_phrase_profile RTL.

module tb_lz76_phrase_profile;
   import lzpp_pkg::*;

   localparam int MAX_LEN     = 1024;
   localparam int SYMBOL_BITS = 8;
   localparam int LONG_HOLD   = 120;

   typedef struct {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   first;
   } symbol_item_type;

   typedef struct {
      logic [NUMBER_BITS-1:0] phrase_number;
      logic                   phrase_closed;
      logic                   overflow;
   } phrase_result_type;

   logic clock;
   logic reset;

   lzpp_req_if #(.SYMBOL_BITS(SYMBOL_BITS)) req_chan ();
   lzpp_rsp_if rsp_chan ();

   lz76_phrase_profile #(
      .MAX_LEN(MAX_LEN),
      .SYMBOL_BITS(SYMBOL_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   symbol_item_type   pending_symbols[$];
   phrase_result_type expected_phrases[$];
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   bit             req_xfer = 1'b0;
   bit             rsp_hold = 1'b0;
   event           rsp_hold_go;

   logic [SYMBOL_BITS-1:0] stored_syms [MAX_LEN];
   bit [MAX_LEN-1:0]       copy_ends;
   int unsigned            string_len;
   int unsigned            closed_count;
   bit                     at_phrase_start;

   function automatic void start_string();
      copy_ends = '0;
      string_len = 0;
      closed_count = 0;
      at_phrase_start = 1'b1;
   endfunction

   function automatic phrase_result_type profile_symbol(input logic [SYMBOL_BITS-1:0] sym,
                                                        input logic first_flag);
      phrase_result_type res;
      bit found;
      bit hit;
      int e;
      found = 1'b0;
      res.phrase_closed = 1'b0;
      res.overflow = 1'b0;
      if (first_flag) begin
         start_string();
      end
      if (string_len >= MAX_LEN) begin
         res.phrase_number = NUMBER_BITS'(at_phrase_start ? closed_count : closed_count + 1);
         res.overflow = 1'b1;
         return res;
      end
      if (at_phrase_start) begin
         for (int j = 0; j < string_len; j++) begin
            copy_ends[j] = (stored_syms[j] == sym);
            found = found | copy_ends[j];
         end
      end else begin
         // Walk downward so each entry still sees the previous symbol's matches.
         for (int j = string_len; j > 0; j--) begin
            e = j - 1;
            if (e > 0) begin
               hit = copy_ends[e-1] && (stored_syms[e] == sym);
            end else begin
               hit = 1'b0;
            end
            copy_ends[e] = hit;
            found = found | hit;
         end
      end
      stored_syms[string_len] = sym;
      string_len++;
      res.phrase_number = NUMBER_BITS'(closed_count + 1);
      if (found) begin
         at_phrase_start = 1'b0;
      end else begin
         copy_ends = '0;
         at_phrase_start = 1'b1;
         closed_count++;
         res.phrase_closed = 1'b1;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [NUMBER_BITS-1:0] want,
                              input logic [NUMBER_BITS-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic add_symbol(input logic [SYMBOL_BITS-1:0] sym, input logic first_flag);
      symbol_item_type item;
      item.symbol = sym;
      item.first = first_flag;
      pending_symbols.push_back(item);
   endtask

   // Symbols come mostly from a few letters so that phrases grow long; a zero letter
   // count gives a string over the full symbol range.
   task automatic add_string(input int len, input int kinds, input bit lead_first);
      logic [SYMBOL_BITS-1:0] letters [4];
      logic [SYMBOL_BITS-1:0] sym;
      foreach (letters[k]) begin
         letters[k] = SYMBOL_BITS'($urandom_range(255));
      end
      for (int i = 0; i < len; i++) begin
         if (kinds == 0 || $urandom_range(15) == 0) begin
            sym = SYMBOL_BITS'($urandom_range(255));
         end else begin
            sym = letters[$urandom_range(kinds - 1)];
         end
         add_symbol(sym, (i == 0) && lead_first);
      end
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_symbols.size() != 0 || expected_phrases.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      phrase_result_type want;
      if (reset) begin
         start_string();
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (expected_phrases.size() == 0) begin
               mismatch_count++;
               $display("%0t: response transfer with nothing expected, actual %0d/%0b/%0b",
                        $time, rsp_chan.phrase_number, rsp_chan.phrase_closed,
                        rsp_chan.overflow);
            end else begin
               want = expected_phrases.pop_front();
               check_field("phrase_number", want.phrase_number, rsp_chan.phrase_number);
               check_field("phrase_closed", NUMBER_BITS'(want.phrase_closed),
                           NUMBER_BITS'(rsp_chan.phrase_closed));
               check_field("overflow", NUMBER_BITS'(want.overflow),
                           NUMBER_BITS'(rsp_chan.overflow));
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            expected_phrases.push_back(profile_symbol(req_chan.symbol, req_chan.first));
            req_xfer = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      bit popped;
      popped = req_xfer;
      if (req_xfer) begin
         pending_symbols.delete(0);
         req_xfer = 1'b0;
      end
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || popped) begin
         if (pending_symbols.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.symbol <= pending_symbols[0].symbol;
            req_chan.first <= pending_symbols[0].first;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always begin
      @(rsp_hold_go);
      rsp_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      int sent;
      int len;
      req_chan.valid = 1'b0;
      req_chan.symbol = '0;
      req_chan.first = 1'b0;
      rsp_chan.ready = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The string after reset is opened without a first flag.
      add_symbol(8'h00, 1'b0);
      add_symbol(8'hFF, 1'b0);
      add_symbol(8'h00, 1'b0);
      add_symbol(8'hFF, 1'b0);
      add_symbol(8'h00, 1'b0);
      add_symbol(8'h00, 1'b0);
      add_symbol(8'h00, 1'b0);
      add_symbol(8'h00, 1'b0);
      // A first flag in the middle of a string drops the old one.
      add_symbol(8'hA5, 1'b1);
      add_symbol(8'h5A, 1'b0);
      add_symbol(8'hA5, 1'b0);
      add_symbol(8'h5A, 1'b0);
      add_symbol(8'hA5, 1'b0);
      add_symbol(8'h5A, 1'b0);
      add_symbol(8'hC3, 1'b0);
      add_symbol(8'h3C, 1'b1);
      add_symbol(8'h3C, 1'b0);
      add_symbol(8'h3C, 1'b0);
      add_symbol(8'h81, 1'b0);
      add_symbol(8'h7E, 1'b1);
      add_symbol(8'h7E, 1'b1);
      drain();

      // Overflow while a phrase is still open.
      for (int i = 0; i < MAX_LEN + 4; i++) begin
         add_symbol(8'h55, i == 0);
      end
      add_string(8, 2, 1'b1);
      drain();

      // Overflow right after a phrase closed, then recovery by a first flag.
      for (int i = 0; i < MAX_LEN - 1; i++) begin
         add_symbol(SYMBOL_BITS'($urandom_range(254)), i == 0);
      end
      add_symbol(8'hFF, 1'b0);
      for (int i = 0; i < 3; i++) begin
         add_symbol(SYMBOL_BITS'($urandom_range(255)), 1'b0);
      end
      add_string(12, 3, 1'b1);
      drain();

      // The receiver holds off while the sender keeps offering symbols.
      add_string(40, 2, 1'b1);
      -> rsp_hold_go;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 49;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 49;
            end
            default: begin
               send_idle_pct = 21;
               recv_stall_pct = 21;
            end
         endcase
         sent = 0;
         while (sent < 125) begin
            if ($urandom_range(9) == 0) begin
               len = $urandom_range(150, 60);
            end else begin
               len = $urandom_range(30, 1);
            end
            add_string(len, ($urandom_range(3) == 0) ? 0 : $urandom_range(4, 1),
                       $urandom_range(19) != 0);
            sent += len;
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout waiting for the block");
      $display("Mismatches found");
      $finish;
   end

endmodule

### lz76_phrase_profile.f
rtl/lzpp_pkg.sv
rtl/lzpp_channels.sv
rtl/lzpp_cell.sv
rtl/lzpp_any_tree.sv
rtl/lz76_phrase_profile.sv
bench/tb_lz76_phrase_profile.sv
